### rtl/ecw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cotangent edge weight pipeline.
// No dependencies; used by ecw_cot and edge_cotangent_weight.
package ecw_pkg;

	localparam int WEIGHT_W = 32;
	localparam int EPS_W    = 8;
	localparam int QUO_W    = 32;

	localparam logic [WEIGHT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [WEIGHT_W-1:0] SAT_NEG = 32'h8000_0000;

	// One clamped cotangent in Q16.16 and its clamp flag.
	typedef struct packed {
		logic                       sat;
		logic signed [WEIGHT_W-1:0] val;
	} cot_res_t;

	// Stages of ecw_cot for difference width dw: five front stages,
	// one per root bit (2*dw + 17), divisor, overflow check,
	// QUO_W quotient bits and the clamp stage.
	function automatic int cot_lat(input int dw);
		return 2 * dw + 57;
	endfunction

endpackage

### rtl/ecw_cot.sv
`timescale 1ns / 1ps
// Pipelined cotangent at one apex: dot, cross norm (bit-per-stage root),
// divide (bit-per-stage quotient) and clamp. Depends on ecw_pkg.
module ecw_cot import ecw_pkg::*; #(
	parameter int DW   = 25,
	parameter int FRAC = 12
) (
	input  logic               clk,
	input  logic               en,
	input  logic [EPS_W-1:0]   eps,
	input  logic [3*DW-1:0]    u,
	input  logic [3*DW-1:0]    v,
	output cot_res_t           res
);

	localparam int PW   = 2 * DW;
	localparam int CW   = PW + 1;
	localparam int MW   = 2 * DW;
	localparam int H    = DW;
	localparam int SQW  = 2 * MW;
	localparam int SW   = SQW + 2;
	localparam int NW   = SW + 32;
	localparam int RW   = NW / 2;
	localparam int DOTW = PW + 2;
	localparam int EPSH = EPS_W + 2 * FRAC;
	localparam int DENW = ((RW > EPSH) ? RW : EPSH) + 1;
	localparam int SDW  = DOTW + 1;

	logic signed [DW-1:0] uu [3];
	logic signed [DW-1:0] vv [3];

	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] xp_s2 [3];
	logic signed [PW-1:0] xn_s2 [3];

	logic signed [DOTW-1:0] dot_s3;
	logic [MW-1:0]          cm_s3 [3];

	logic [PW-1:0]   hh_s4 [3];
	logic [PW-1:0]   hl_s4 [3];
	logic [PW-1:0]   ll_s4 [3];
	logic [DOTW-1:0] dmag_s4;
	logic            dneg_s4;

	logic [SQW-1:0]  sq_s5 [3];
	logic [DOTW-1:0] dmag_s5;
	logic            dneg_s5;

	logic [NW-1:0]  sq_rem_s  [RW+1];
	logic [RW-1:0]  sq_root_s [RW+1];
	logic [SDW-1:0] sq_sd_s   [RW+1];

	logic [DENW-1:0] den_sd;
	logic [SDW-1:0]  side_sd;

	logic [DENW-1:0]  dv_rem_s [QUO_W+1];
	logic [QUO_W-1:0] dv_q_s   [QUO_W+1];
	logic [DENW-1:0]  dv_den_s [QUO_W+1];
	logic [3:0]       dv_fl_s  [QUO_W+1];

	logic [DENW-1:0] dmag_ext;
	logic            big;
	logic [QUO_W-1:0] q_fin;

	genvar k;

	for (k = 0; k < 3; k++) begin : g_axis
		localparam int A = (k + 1) % 3;
		localparam int B = (k + 2) % 3;
		logic signed [CW-1:0] cx;

		assign uu[k] = u[k*DW +: DW];
		assign vv[k] = v[k*DW +: DW];
		assign cx = $signed({xp_s2[k][PW-1], xp_s2[k]}) - $signed({xn_s2[k][PW-1], xn_s2[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				dd_s2[k] <= uu[k] * vv[k];
				xp_s2[k] <= uu[A] * vv[B];
				xn_s2[k] <= uu[B] * vv[A];
				cm_s3[k] <= cx[CW-1] ? MW'(-cx) : MW'(cx);
				hh_s4[k] <= cm_s3[k][MW-1:H] * cm_s3[k][MW-1:H];
				hl_s4[k] <= cm_s3[k][MW-1:H] * cm_s3[k][H-1:0];
				ll_s4[k] <= cm_s3[k][H-1:0] * cm_s3[k][H-1:0];
				sq_s5[k] <= (SQW'(hh_s4[k]) << (2 * H)) + (SQW'(hl_s4[k]) << (H + 1))
					+ SQW'(ll_s4[k]);
			end
		end
	end

	// Dot product, sign/magnitude split, squared norm sum.
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3  <= $signed({{2{dd_s2[0][PW-1]}}, dd_s2[0]})
				+ $signed({{2{dd_s2[1][PW-1]}}, dd_s2[1]})
				+ $signed({{2{dd_s2[2][PW-1]}}, dd_s2[2]});
			dneg_s4 <= dot_s3[DOTW-1];
			dmag_s4 <= dot_s3[DOTW-1] ? DOTW'(-dot_s3) : DOTW'(dot_s3);
			dneg_s5 <= dneg_s4;
			dmag_s5 <= dmag_s4;
			sq_rem_s[0]  <= {SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]), 32'b0};
			sq_root_s[0] <= '0;
			sq_sd_s[0]   <= {dneg_s5, dmag_s5};
		end
	end

	// Square root, one result bit per stage from the top.
	for (k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [NW-1:0] trial;

		assign trial = (NW'(sq_root_s[k]) << (B + 1)) | (NW'(1'b1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				sq_sd_s[k+1] <= sq_sd_s[k];
				if (sq_rem_s[k] >= trial) begin
					sq_rem_s[k+1]  <= sq_rem_s[k] - trial;
					sq_root_s[k+1] <= sq_root_s[k] | (RW'(1'b1) << B);
				end else begin
					sq_rem_s[k+1]  <= sq_rem_s[k];
					sq_root_s[k+1] <= sq_root_s[k];
				end
			end
		end
	end

	assign dmag_ext = DENW'(side_sd[DOTW-1:0]);

	// Divisor, then overflow check: quotient reaches 2^32 when |D| >= divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			den_sd      <= DENW'(sq_root_s[RW]) + (DENW'(eps) << (2 * FRAC));
			side_sd     <= sq_sd_s[RW];
			dv_den_s[0] <= den_sd;
			dv_q_s[0]   <= '0;
			dv_rem_s[0] <= (dmag_ext >= den_sd) ? '0 : dmag_ext;
			dv_fl_s[0]  <= {side_sd[DOTW], side_sd[DOTW-1:0] == '0,
				dmag_ext >= den_sd, den_sd == '0};
		end
	end

	// Restoring division, one quotient bit per stage.
	for (k = 0; k < QUO_W; k++) begin : g_div
		logic [DENW:0] r2;
		logic          ge;

		assign r2 = {dv_rem_s[k], 1'b0};
		assign ge = r2 >= {1'b0, dv_den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[k+1] <= dv_den_s[k];
				dv_fl_s[k+1]  <= dv_fl_s[k];
				dv_q_s[k+1]   <= {dv_q_s[k][QUO_W-2:0], ge};
				dv_rem_s[k+1] <= ge ? DENW'(r2 - {1'b0, dv_den_s[k]}) : r2[DENW-1:0];
			end
		end
	end

	// Flags: [3] negative, [2] dot zero, [1] overflow, [0] divisor zero.
	assign q_fin = dv_q_s[QUO_W];
	assign big   = dv_fl_s[QUO_W][1] ||
		(dv_fl_s[QUO_W][3] ? (q_fin > SAT_NEG) : q_fin[QUO_W-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			res.sat <= dv_fl_s[QUO_W][0] || big;
			if (dv_fl_s[QUO_W][0] && dv_fl_s[QUO_W][2]) begin
				res.val <= '0;
			end else if (big) begin
				res.val <= dv_fl_s[QUO_W][3] ? SAT_NEG : SAT_POS;
			end else begin
				res.val <= dv_fl_s[QUO_W][3] ? -q_fin : q_fin;
			end
		end
	end

endmodule

### rtl/edge_cotangent_weight.sv
`timescale 1ns / 1ps
// Top level of the cotangent Laplacian edge weight pipeline.
// Depends on ecw_pkg and ecw_cot (two instances, one per apex).
//
// Takes one mesh edge per beat (end vertices i, j and opposite apexes a, b,
// signed fixed point) and returns one beat with cot(a) + cot(b) as signed
// Q16.16. Each cotangent is dot / (|cross| + epsilon_lsb * 2^-16), truncated
// toward zero and clamped to 32 bits; the sum is clamped again, and the
// saturated flag marks any clamp or a zero divisor (zero cross product with
// epsilon_lsb at 0, which gives +max, -max or 0 after the sign of the dot).
// The block is fully pipelined and accepts one edge every cycle while the
// output is not stalled. Its depth is set by the square root, which
// resolves one root bit per stage, and the divider, which resolves one
// quotient bit per stage. A stalled output freezes the whole pipe in place;
// s_tready follows the output register, so nothing is lost or repeated.
// Write epsilon_lsb (reset 1) only while no edge is in flight.
module edge_cotangent_weight import ecw_pkg::*; #(
	parameter int COORD_WIDTH     = 24,
	parameter int COORD_FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [EPS_W-1:0]    cfg_wdata,   // epsilon_lsb
	input  logic                s_tvalid,
	output logic                s_tready,
	// edge_i_x, edge_i_y, edge_i_z, edge_j_x, edge_j_y, edge_j_z,
	// apex_a_x, apex_a_y, apex_a_z, apex_b_x, apex_b_y, apex_b_z, zero pad
	input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [WEIGHT_W-1:0] m_tdata,     // weight
	output logic [0:0]          m_tuser      // saturated
);

	localparam int DW  = COORD_WIDTH + 1;
	localparam int LAT = cot_lat(DW);

	logic [EPS_W-1:0] eps_q;
	logic             en;
	logic             vld_s1;
	logic [LAT-1:0]   vld_q;

	logic [3*DW-1:0] ua_s1, va_s1, ub_s1, vb_s1;
	cot_res_t        cot_a, cot_b;
	logic signed [WEIGHT_W:0] sum;

	// Advance the whole pipe unless a result waits at the output.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_W'(1);
		end else if (cfg_wen) begin
			eps_q <= cfg_wdata;
		end
	end

	// Edge vectors from each apex to both ends, one bit wider than a coordinate.
	genvar d;
	for (d = 0; d < 3; d++) begin : g_diff
		logic signed [COORD_WIDTH-1:0] pi, pj, pa, pb;

		assign pi = s_tdata[d*COORD_WIDTH +: COORD_WIDTH];
		assign pj = s_tdata[(3+d)*COORD_WIDTH +: COORD_WIDTH];
		assign pa = s_tdata[(6+d)*COORD_WIDTH +: COORD_WIDTH];
		assign pb = s_tdata[(9+d)*COORD_WIDTH +: COORD_WIDTH];

		always_ff @(posedge clk) begin
			if (en) begin
				ua_s1[d*DW +: DW] <= {pi[COORD_WIDTH-1], pi} - {pa[COORD_WIDTH-1], pa};
				va_s1[d*DW +: DW] <= {pj[COORD_WIDTH-1], pj} - {pa[COORD_WIDTH-1], pa};
				ub_s1[d*DW +: DW] <= {pi[COORD_WIDTH-1], pi} - {pb[COORD_WIDTH-1], pb};
				vb_s1[d*DW +: DW] <= {pj[COORD_WIDTH-1], pj} - {pb[COORD_WIDTH-1], pb};
			end
		end
	end

	ecw_cot #(.DW(DW), .FRAC(COORD_FRAC_BITS)) u_cot_a (
		.clk (clk),
		.en  (en),
		.eps (eps_q),
		.u   (ua_s1),
		.v   (va_s1),
		.res (cot_a)
	);

	ecw_cot #(.DW(DW), .FRAC(COORD_FRAC_BITS)) u_cot_b (
		.clk (clk),
		.en  (en),
		.eps (eps_q),
		.u   (ub_s1),
		.v   (vb_s1),
		.res (cot_b)
	);

	// Valid bits travel alongside the data, one per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1   <= s_tvalid;
			vld_q    <= {vld_q[LAT-2:0], vld_s1};
			m_tvalid <= vld_q[LAT-1];
		end
	end

	assign sum = {cot_a.val[WEIGHT_W-1], cot_a.val} + {cot_b.val[WEIGHT_W-1], cot_b.val};

	// Add both cotangents and clamp the sum into Q16.16.
	always_ff @(posedge clk) begin
		if (en) begin
			if (sum[WEIGHT_W] != sum[WEIGHT_W-1]) begin
				m_tdata    <= sum[WEIGHT_W] ? SAT_NEG : SAT_POS;
				m_tuser[0] <= 1'b1;
			end else begin
				m_tdata    <= sum[WEIGHT_W-1:0];
				m_tuser[0] <= cot_a.sat || cot_b.sat;
			end
		end
	end

endmodule
